FILE: hw/rtl/lcfr_pkg.sv
// Shared types and constants for the length/checksum frame receiver.
package lcfr_pkg;

   // Frame layout: position of the length byte, and bytes added around the length.
   localparam logic [8:0] LENGTH_FIELD_POS = 9'd1;
   localparam logic [9:0] FRAME_OVERHEAD   = 10'd3;

   // Reset values of the configuration registers.
   localparam logic [7:0] START_BYTE_RESET    = 8'd85;
   localparam logic [8:0] MAX_FRAME_LEN_RESET = 9'd64;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_START_BYTE    = 1'b0,
      CSR_MAX_FRAME_LEN = 1'b1
   } csr_index_type;

   // Per-byte status codes.
   typedef enum logic [2:0] {
      ST_DROP  = 3'd0,
      ST_START = 3'd1,
      ST_BODY  = 3'd2,
      ST_OK    = 3'd3,
      ST_BAD   = 3'd4,
      ST_OVER  = 3'd5
   } status_type;

   // Configuration values seen by the frame tracker.
   typedef struct packed {
      logic [7:0] start_byte;
      logic [8:0] max_frame_len;
   } cfg_type;

   // One result item.
   typedef struct packed {
      logic [7:0] echo_byte;
      logic [8:0] position;
      status_type status;
   } result_type;

endpackage

FILE: hw/rtl/lcfr_frame_tracker.sv
// Frame tracking state and the per-byte classification logic.
module lcfr_frame_tracker
   import lcfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       byte_accept,
   input  logic [7:0] data_byte,
   output result_type result
);

   logic       receiving_ff, receiving_in;
   logic [8:0] byte_count_ff, byte_count_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic [7:0] length_field_ff, length_field_in;

   logic       at_length;
   logic       over_position;
   logic       over_length;
   logic       short_length;
   logic [7:0] length_eff;
   logic       at_end;

   // Checks on the current byte against the frame state.
   always_comb begin
      at_length     = (byte_count_ff == LENGTH_FIELD_POS);
      over_position = ({1'b0, byte_count_ff} + 10'd1) > {1'b0, cfg.max_frame_len};
      over_length   = at_length &&
                      (({2'b00, data_byte} + FRAME_OVERHEAD) > {1'b0, cfg.max_frame_len});
      short_length  = at_length &&
                      (({2'b00, data_byte} + 10'd2) < {1'b0, byte_count_ff});
      length_eff    = at_length ? data_byte : length_field_ff;
      at_end        = (byte_count_ff >= LENGTH_FIELD_POS) &&
                      ({1'b0, byte_count_ff} == ({2'b00, length_eff} + 10'd2));
   end

   // Result classification and next state.
   always_comb begin
      receiving_in     = receiving_ff;
      byte_count_in    = byte_count_ff;
      running_sum_in   = running_sum_ff;
      length_field_in  = length_field_ff;
      result.echo_byte = data_byte;
      result.position  = byte_count_ff;
      result.status    = ST_BODY;
      if (!receiving_ff) begin
         result.position = '0;
         if (data_byte == cfg.start_byte) begin
            result.status  = ST_START;
            receiving_in   = 1'b1;
            byte_count_in  = 9'd1;
            running_sum_in = data_byte;
         end else begin
            result.status = ST_DROP;
         end
      end else begin
         if (at_length && !over_position) begin
            length_field_in = data_byte;
         end
         priority if (over_position || over_length) begin
            result.status = ST_OVER;
         end else if (short_length) begin
            result.status = ST_BAD;
         end else if (at_end) begin
            result.status = (data_byte == running_sum_ff) ? ST_OK : ST_BAD;
         end else begin
            result.status = ST_BODY;
         end
         if (result.status == ST_BODY) begin
            running_sum_in = running_sum_ff + data_byte;
            byte_count_in  = byte_count_ff + 9'd1;
         end else begin
            receiving_in   = 1'b0;
            byte_count_in  = '0;
            running_sum_in = '0;
         end
      end
   end

   // State registers advance on each accepted transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff    <= 1'b0;
         byte_count_ff   <= '0;
         running_sum_ff  <= '0;
         length_field_ff <= '0;
      end else if (byte_accept) begin
         receiving_ff    <= receiving_in;
         byte_count_ff   <= byte_count_in;
         running_sum_ff  <= running_sum_in;
         length_field_ff <= length_field_in;
      end
   end

`ifndef SYNTHESIS
   a_hunt_clear: assert property (@(posedge clock) disable iff (reset)
      !receiving_ff |-> (byte_count_ff == 9'd0 && running_sum_ff == 8'd0))
      else $error("frame state not cleared while hunting");
   a_recv_count: assert property (@(posedge clock) disable iff (reset)
      receiving_ff |-> (byte_count_ff != 9'd0))
      else $error("zero byte count inside a frame");
   a_start_opens: assert property (@(posedge clock) disable iff (reset)
      (byte_accept && result.status == ST_START) |=> (receiving_ff && byte_count_ff == 9'd1))
      else $error("start byte did not open a frame");
   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      (byte_accept && (result.status == ST_OK || result.status == ST_BAD ||
                       result.status == ST_OVER)) |=> !receiving_ff)
      else $error("frame end did not return to hunting");
`endif

endmodule

FILE: hw/rtl/lcfr_output_skid.sv
// Result register with a skid stage between the input and result channels.
module lcfr_output_skid
   import lcfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_stall,
   input  result_type in_data,
   output logic       out_valid,
   input  logic       out_stall,
   output result_type out_data
);

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       in_accept;
   logic       out_accept;

   assign in_stall   = skid_valid_ff;
   assign in_accept  = in_valid && !skid_valid_ff;
   assign out_accept = out_valid_ff && !out_stall;
   assign out_valid  = out_valid_ff;
   assign out_data   = out_data_ff;

   // Route an incoming transfer to the result register or the skid stage.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (out_accept || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_accept;
            out_data_in  = in_data;
         end
      end else if (in_accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   // Control flags take reset; payload registers do not.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

`ifndef SYNTHESIS
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds data ahead of the result register");
   a_accept_shows: assert property (@(posedge clock) disable iff (reset)
      in_accept |=> out_valid_ff)
      else $error("accepted transfer not presented");
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_accept) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid stage did not move forward");
`endif

endmodule

FILE: hw/rtl/length_checksum_frame_receiver_core.sv
// Top level of the length/checksum frame receiver: configuration registers and wiring.
// Takes one received byte per transfer and returns one result per byte: the byte itself,
// its position in the frame and a status (dropped while hunting, start, body, end with
// good checksum, end with bad checksum, oversize). A new byte is accepted every clock
// cycle while req_stall is low; each result is registered in the output buffer; the frame
// state update and classification are one adder and a few compares ahead of the result
// register. A two-entry output buffer (result register, skid stage) lets input go on after
// rsp_stall rises until the skid fills. The start byte and maximum frame length registers
// reset to 85 and 64 and should be written only while no results are outstanding.
module length_checksum_frame_receiver_core
   import lcfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_echo_byte,
   output logic [8:0] rsp_position,
   output logic [2:0] rsp_status,
   input  logic       csr_write_enable,
   input  logic [0:0] csr_index,
   input  logic [8:0] csr_write_data
);

   logic [7:0] start_byte_ff;
   logic [8:0] max_frame_len_ff;
   cfg_type    cfg;
   logic       byte_accept;
   result_type result;
   result_type rsp_data;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff    <= START_BYTE_RESET;
         max_frame_len_ff <= MAX_FRAME_LEN_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_BYTE:    start_byte_ff    <= csr_write_data[7:0];
            CSR_MAX_FRAME_LEN: max_frame_len_ff <= csr_write_data;
            default:           ;
         endcase
      end
   end

   assign cfg.start_byte    = start_byte_ff;
   assign cfg.max_frame_len = max_frame_len_ff;
   assign byte_accept       = req_valid && !req_stall;

   lcfr_frame_tracker u_tracker (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .byte_accept (byte_accept),
      .data_byte   (req_data_byte),
      .result      (result)
   );

   lcfr_output_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (result),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_echo_byte = rsp_data.echo_byte;
   assign rsp_position  = rsp_data.position;
   assign rsp_status    = rsp_data.status;

endmodule
